### rtl/htfcc_pkg.sv
package htfcc_pkg;

  // byte places within one six-byte sensor frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // crc-8, polynomial x^8+x^5+x^4+1, msb first
  localparam logic [7:0] CRC_POLY = 8'h31;

  // temperature: 1000 + trunc((8786*S - 153518080) / 327680)
  localparam int unsigned TEMP_GAIN   = 8786;
  localparam int unsigned TEMP_OFFSET = 153518080;
  localparam int unsigned TEMP_BASE   = 1000;
  // 52429 / 2^18 is 1/5 plus a small excess, exact for 13-bit dividends
  localparam int unsigned RECIP_FIVE  = 52429;

  // humidity: max(0, trunc((1250*S - 3932160) / 65536))
  localparam int unsigned HUM_GAIN   = 1250;
  localparam int unsigned HUM_OFFSET = 3932160;

  // limits of the converted codes
  localparam logic [11:0] TEMP_CODE_MIN = 12'd532;
  localparam logic [11:0] TEMP_CODE_MAX = 12'd2288;
  localparam logic [10:0] HUM_CODE_MAX  = 11'd1189;

  // one result transaction
  typedef struct packed {
    logic        humidity_crc_ok;
    logic        temperature_crc_ok;
    logic [10:0] humidity_code;
    logic [11:0] temperature_code;
  } result_t;

  // one byte through the crc-8 shift register
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/humidity_temp_frame_check_convert_top.sv
// channel  | direction | tdata (low bit up)                        | tuser
// ---------+-----------+-------------------------------------------+-------------
// s_axis   | in        | [7:0] data_byte                           | frame_start
// m_axis   | out       | [11:0] temperature_code, [22:12]          | -
//          |           | humidity_code, [23] temperature_crc_ok,   |
//          |           | [24] humidity_crc_ok, [31:25] zero        |
//
// one byte is taken per cycle while s_axis_tready_o is high; the sixth byte of
// a frame yields a result in the output register or skid slot, others yield nothing
// temperature is scaled when its crc byte arrives; its divide by five and the
// humidity scaling run in the cycle that takes the humidity crc byte
// a two-entry output buffer (output register plus skid slot) lets bytes keep
// flowing while a result waits; s_axis_tready_o drops only when both are full
// reset is asynchronous, active low, and puts the byte order at temperature msb

module humidity_temp_frame_check_convert_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] frame_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [11:0] temperature_code, [22:12] humidity_code,
                                        // [23] temperature_crc_ok, [24] humidity_crc_ok
);

  // frame state
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  hi_q, hi_d;
  logic [7:0]  lo_q, lo_d;
  logic [12:0] temp_quo_q, temp_quo_d;
  logic        temp_neg_q, temp_neg_d;
  logic        temp_ok_q, temp_ok_d;

  // output buffer
  logic                  out_valid_q, skid_valid_q;
  htfcc_pkg::result_t    out_q, skid_q;

  logic                  in_acc;
  logic                  out_pop;
  logic                  res_push;
  logic [2:0]            pos_eff;
  logic [7:0]            crc_new;
  logic [15:0]           word;
  logic [29:0]           t_prod;
  logic                  t_neg;
  logic [29:0]           t_mag;
  logic [28:0]           t_div5;
  logic [10:0]           t_q;
  logic [11:0]           temp_code;
  logic [26:0]           h_prod;
  logic [26:0]           h_diff;
  logic [10:0]           hum_code;
  htfcc_pkg::result_t    res;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_pop = out_valid_q && m_axis_tready_i;

  // frame start or a stray place restarts at temperature msb
  assign pos_eff = (s_axis_tuser_i || (pos_q > htfcc_pkg::POS_H_CRC)) ?
                   htfcc_pkg::POS_T_MSB : pos_q;

  // running crc; the msb of a word starts from zero
  assign crc_new = htfcc_pkg::crc8_update(
                     ((pos_eff == htfcc_pkg::POS_T_MSB) || (pos_eff == htfcc_pkg::POS_H_MSB)) ?
                     8'h00 : crc_q, s_axis_tdata_i);

  // held word with status bits cleared
  assign word = {hi_q, lo_q[7:2], 2'b00};

  // temperature numerator as sign and magnitude, magnitude divided by 65536
  assign t_prod = 30'(word) * 30'(htfcc_pkg::TEMP_GAIN);
  assign t_neg  = t_prod < 30'(htfcc_pkg::TEMP_OFFSET);
  assign t_mag  = t_neg ? (30'(htfcc_pkg::TEMP_OFFSET) - t_prod) :
                          (t_prod - 30'(htfcc_pkg::TEMP_OFFSET));

  // remaining divide by five through the reciprocal, then the offset
  assign t_div5    = 29'(temp_quo_q) * 29'(htfcc_pkg::RECIP_FIVE);
  assign t_q       = t_div5[28:18];
  assign temp_code = temp_neg_q ? (12'(htfcc_pkg::TEMP_BASE) - 12'(t_q)) :
                                  (12'(htfcc_pkg::TEMP_BASE) + 12'(t_q));

  // humidity scaling, negative results clamp to zero
  assign h_prod   = 27'(word) * 27'(htfcc_pkg::HUM_GAIN);
  assign h_diff   = h_prod - 27'(htfcc_pkg::HUM_OFFSET);
  assign hum_code = (h_prod < 27'(htfcc_pkg::HUM_OFFSET)) ? 11'd0 : h_diff[26:16];

  assign res.temperature_code   = temp_code;
  assign res.humidity_code      = hum_code;
  assign res.temperature_crc_ok = temp_ok_q;
  assign res.humidity_crc_ok    = (crc_q == s_axis_tdata_i);

  // byte order and per-place updates
  always_comb begin
    pos_d      = pos_q;
    crc_d      = crc_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    temp_quo_d = temp_quo_q;
    temp_neg_d = temp_neg_q;
    temp_ok_d  = temp_ok_q;
    res_push   = 1'b0;
    if (in_acc) begin
      case (pos_eff)
        htfcc_pkg::POS_T_MSB, htfcc_pkg::POS_H_MSB: begin
          hi_d  = s_axis_tdata_i;
          crc_d = crc_new;
          pos_d = pos_eff + 3'd1;
        end
        htfcc_pkg::POS_T_LSB, htfcc_pkg::POS_H_LSB: begin
          lo_d  = s_axis_tdata_i;
          crc_d = crc_new;
          pos_d = pos_eff + 3'd1;
        end
        htfcc_pkg::POS_T_CRC: begin
          temp_quo_d = t_mag[28:16];
          temp_neg_d = t_neg;
          temp_ok_d  = (crc_q == s_axis_tdata_i);
          pos_d      = htfcc_pkg::POS_H_MSB;
        end
        htfcc_pkg::POS_H_CRC: begin
          res_push = 1'b1;
          pos_d    = htfcc_pkg::POS_T_MSB;
        end
        default: begin
          pos_d = htfcc_pkg::POS_T_MSB;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= htfcc_pkg::POS_T_MSB;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q      <= crc_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    temp_quo_q <= temp_quo_d;
    temp_neg_q <= temp_neg_d;
    temp_ok_q  <= temp_ok_d;
  end

  // output register with skid slot behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (res_push) begin
        if (out_valid_q && !out_pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (res_push) begin
      if (out_valid_q && !out_pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign s_axis_tready_o = !skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q};

  // the skid slot only fills behind a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid slot full while output register empty");

  // byte order never leaves the six frame places
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= htfcc_pkg::POS_H_CRC)
    else $error("byte place out of range");

  // a result arriving at a stalled output must park in the skid slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && out_valid_q && !m_axis_tready_i) |=> skid_valid_q)
    else $error("result lost at stalled output");

  // converted codes stay inside the sensor's range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_q.temperature_code >= htfcc_pkg::TEMP_CODE_MIN) &&
                        (out_q.temperature_code <= htfcc_pkg::TEMP_CODE_MAX) &&
                        (out_q.humidity_code <= htfcc_pkg::HUM_CODE_MAX))
    else $error("converted code out of range");

endmodule
